@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared word types, operation and status codes, and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned TAG_WIDTH_DEF   = 16;
  localparam int unsigned PRIO_W          = 32;
  localparam int unsigned TAG_FIELD_W     = 16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_TOP    = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [PRIO_W-1:0] priority_req;
    logic [TAG_FIELD_W-1:0]   value_tag;
  } spq_in_t;

  typedef struct packed {
    logic                   has_value;
    logic [TAG_FIELD_W-1:0] head_value;
    logic [1:0]             status;
  } spq_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_WRNEW,
    S_TOPRD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic       capture;
    logic       rd_tail;
    logic       rd_prev;
    logic       rd_head;
    logic       wr_shift;
    logic       wr_new_above;
    logic       wr_new_head;
    logic       count_inc;
    logic       pop;
    logic       res_set;
    logic [1:0] res_status;
    logic       res_top;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       empty;
    logic       full;
    logic       idx_zero;
    logic       shift;
    logic       out_free;
  } dp_sts_t;

endpackage

@@ sv/spq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Circular entry store, head pointer, fill count, scan index, result and
// output registers.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_WIDTH   = TAG_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spq_in_t  in_word_i,
  input  dp_cmd_t  cmd_i,
  output dp_sts_t  sts_o,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output spq_out_t out_word_o
);

  localparam int unsigned AW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned StoreW = (TAG_WIDTH < TAG_FIELD_W) ? TAG_WIDTH : TAG_FIELD_W;
  localparam int unsigned EntryW = PRIO_W + StoreW;
  localparam logic [AW:0] DepthA = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] base,
                                            input logic [AW-1:0] offset);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= DepthA) begin
      sum = sum - DepthA;
    end
    return sum[AW-1:0];
  endfunction

  spq_in_t                req_q;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic                   res_has_q, res_has_d;
  logic [TAG_FIELD_W-1:0] res_head_q, res_head_d;
  logic [1:0]             res_status_q, res_status_d;
  logic                   out_valid_q, out_valid_d;
  spq_out_t               out_word_q;

  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [EntryW-1:0]      wr_data, rd_data, new_entry;
  logic [AW-1:0]          last_idx, above_idx, prev_idx;
  logic signed [PRIO_W-1:0] rd_prio;

  assign last_idx  = AW'(count_q - CW'(1));
  assign above_idx = idx_q + AW'(1);
  assign prev_idx  = idx_q - AW'(1);
  assign new_entry = {req_q.priority_req, req_q.value_tag[StoreW-1:0]};
  assign rd_prio   = rd_data[EntryW-1:StoreW];

  always_comb begin
    rd_en   = cmd_i.rd_tail | cmd_i.rd_prev | cmd_i.rd_head;
    rd_addr = head_q;
    if (cmd_i.rd_tail) begin
      rd_addr = to_phys(head_q, last_idx);
    end else if (cmd_i.rd_prev) begin
      rd_addr = to_phys(head_q, prev_idx);
    end
  end

  always_comb begin
    wr_en   = cmd_i.wr_shift | cmd_i.wr_new_above | cmd_i.wr_new_head;
    wr_addr = to_phys(head_q, above_idx);
    wr_data = new_entry;
    if (cmd_i.wr_shift) begin
      wr_data = rd_data;
    end else if (cmd_i.wr_new_head) begin
      wr_addr = head_q;
    end
  end

  spq_ram #(
    .Width (EntryW),
    .Depth (QUEUE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.pop) begin
      head_d  = to_phys(head_q, AW'(1));
      count_d = count_q - CW'(1);
    end else if (cmd_i.count_inc) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.rd_tail) begin
      idx_d = last_idx;
    end else if (cmd_i.rd_prev) begin
      idx_d = prev_idx;
    end
  end

  always_comb begin
    res_has_d    = res_has_q;
    res_head_d   = res_head_q;
    res_status_d = res_status_q;
    if (cmd_i.res_top) begin
      res_has_d            = 1'b1;
      res_head_d           = '0;
      res_head_d[StoreW-1:0] = rd_data[StoreW-1:0];
      res_status_d         = ST_DONE;
    end else if (cmd_i.res_set) begin
      res_has_d    = 1'b0;
      res_head_d   = '0;
      res_status_d = cmd_i.res_status;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_word_i;
    end
    idx_q        <= idx_d;
    res_has_q    <= res_has_d;
    res_head_q   <= res_head_d;
    res_status_q <= res_status_d;
    if (cmd_i.out_load) begin
      out_word_q <= '{has_value: res_has_q, head_value: res_head_q, status: res_status_q};
    end
  end

  assign sts_o.req_type = req_q.req_type;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q >= DepthC);
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.shift    = (rd_prio <= req_q.priority_req);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ sv/spq_controller.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences one request at a time: decode, tail-to-head insertion scan,
// head read, and hand-off to the output register.
// ----------------------------------------------------------------------------
module spq_controller import spq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (req_e'(sts_i.req_type))
          REQ_INSERT: state_d = (sts_i.full || sts_i.empty) ? S_RESP : S_SCAN;
          REQ_TOP:    state_d = sts_i.empty ? S_RESP : S_TOPRD;
          REQ_POP:    state_d = S_RESP;
          default:    state_d = S_RESP;
        endcase
      end
      S_SCAN: begin
        if (sts_i.shift && sts_i.idx_zero) begin
          state_d = S_WRNEW;
        end else if (!sts_i.shift) begin
          state_d = S_RESP;
        end
      end
      S_WRNEW: state_d = S_RESP;
      S_TOPRD: state_d = S_RESP;
      S_RESP: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = ST_DONE;
    in_stall_o       = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: cmd_o.capture = in_valid_i;
      S_DECODE: begin
        cmd_o.res_set = 1'b1;
        unique case (req_e'(sts_i.req_type))
          REQ_INSERT: begin
            if (sts_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else if (sts_i.empty) begin
              cmd_o.wr_new_head = 1'b1;
              cmd_o.count_inc   = 1'b1;
            end else begin
              cmd_o.rd_tail = 1'b1;
            end
          end
          REQ_POP: begin
            if (sts_i.empty) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.pop = 1'b1;
            end
          end
          REQ_TOP: begin
            if (sts_i.empty) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.rd_head = 1'b1;
            end
          end
          default: cmd_o.res_status = ST_DONE;
        endcase
      end
      S_SCAN: begin
        if (sts_i.shift) begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.rd_prev  = !sts_i.idx_zero;
        end else begin
          cmd_o.wr_new_above = 1'b1;
          cmd_o.count_inc    = 1'b1;
        end
      end
      S_WRNEW: begin
        cmd_o.wr_new_head = 1'b1;
        cmd_o.count_inc   = 1'b1;
      end
      S_TOPRD: cmd_o.res_top = 1'b1;
      S_RESP:  cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ sv/sorted_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// A fixed-depth priority queue, highest priority at the head, equal
// priorities leaving newest first. Each request word gives one result word.
// ----------------------------------------------------------------------------
// The unit takes one request at a time. A pop, a no-op, a rejected insert or
// an insert into an empty queue goes from decode straight to the response
// state, and a top first reads the head entry. An insert into a non-empty
// queue scans from the tail, moving every stored entry whose priority is equal
// to or below the new one one place toward the tail, one per cycle, through
// the single read and single write port of the entry RAM, and then writes the
// new entry. The store is a circular buffer, so a pop only moves the head
// pointer. A finished result waits in the output register until taken, and a
// new result cannot be loaded while a stalled word still waits there; the next
// request can be accepted in the cycle after the result is loaded. No clearing
// pass follows reset.
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_WIDTH   = TAG_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  spq_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output spq_out_t out_word_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  spq_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Request accepted while the previous one is still in progress.");

  a_no_insert_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.count_inc |-> !sts.full && !cmd.pop)
    else $error("Entry count raised on a full store.");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !sts.empty)
    else $error("Head removed from an empty store.");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("Output register overwritten while its word waits.");
`endif

endmodule
